// ===== rtl/core/its_pkg.sv =====
// Package for the indentation token scanner.
// Holds byte codes, token kinds, byte classes and the controller/datapath structs.
// No dependencies.
package its_pkg;

   localparam logic [7:0] CHAR_EOF     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_HASH    = 8'h23;

   localparam logic [4:0] TAB_WIDTH_RESET = 5'd4;

   // Upper bound on the tokens that one byte may cause.
   localparam int MAX_TOKENS = 32;
   localparam int EMIT_W     = $clog2(MAX_TOKENS + 1);

   typedef enum logic [1:0] {
      TOK_INDENT  = 2'd0,
      TOK_DEDENT  = 2'd1,
      TOK_NEWLINE = 2'd2
   } token_kind_type;

   typedef enum logic [2:0] {
      CLS_EOF,
      CLS_NEWLINE,
      CLS_SPACE,
      CLS_TAB,
      CLS_CR,
      CLS_HASH,
      CLS_OTHER
   } byte_class_type;

   function automatic byte_class_type classify(input logic [7:0] c);
      byte_class_type cls;
      case (c)
         CHAR_EOF:     cls = CLS_EOF;
         CHAR_NEWLINE: cls = CLS_NEWLINE;
         CHAR_SPACE:   cls = CLS_SPACE;
         CHAR_TAB:     cls = CLS_TAB;
         CHAR_CR:      cls = CLS_CR;
         CHAR_HASH:    cls = CLS_HASH;
         default:      cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           take_ready;
      logic           clr_indent;
      logic           add_space;
      logic           add_tab;
      logic           set_comment;
      logic           clr_comment;
      logic           set_newline;
      logic           clr_newline;
      logic           push;
      logic           load_target;
      logic           target_zero;
      logic           rd_below;
      logic           pop;
      logic           emit;
      token_kind_type emit_kind;
      logic           emit_last;
      logic           emit_ovf;
   } its_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      byte_class_type byte_class;
      logic           in_comment;
      logic           seen_newline;
      logic           indent_gt_top;
      logic           indent_lt_top;
      logic           stack_full;
      logic           above_base;
      logic           more;
      logic           out_free;
   } its_status_type;

endpackage

// ===== rtl/core/its_datapath.sv =====
// Datapath of the indentation token scanner: level stack memory, indent
// counter, mode flags, tab width register and result register. Uses its_pkg.
module its_datapath import its_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int LEVEL_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_char_code,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [4:0]          csr_write_data,
   input  its_cmd_type         cmd,
   output its_status_type      st,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_token_kind,
   output logic                rsp_last_token,
   output logic                rsp_stack_overflow
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   logic [LEVEL_BITS-1:0] level_stack_ff [STACK_DEPTH];
   logic [LEVEL_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     rd_addr;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LEVEL_BITS-1:0] top_ff, top_in;
   logic [LEVEL_BITS-1:0] indent_ff, indent_in;
   logic [LEVEL_BITS-1:0] target_ff, target_in;
   logic [EMIT_W-1:0]     emitted_ff, emitted_in;
   logic                  comment_ff, comment_in;
   logic                  newline_ff, newline_in;
   logic [4:0]            tab_width_ff, tab_width_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   token_kind_type        kind_ff;
   logic                  last_ff;
   logic                  ovf_ff;

   logic [4:0]            add_amount;
   logic [LEVEL_BITS:0]   indent_sum;
   logic [EMIT_W:0]       emitted_next;

   // Stack memory: one write port for pushes, one registered read port.
   assign rd_addr = ADDR_W'(count_ff - CNT_W'(2));

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         level_stack_ff[count_ff[ADDR_W-1:0]] <= indent_ff;
      end
      if (cmd.rd_below) begin
         rd_data_ff <= level_stack_ff[rd_addr];
      end
   end

   always_comb begin
      add_amount = cmd.add_tab ? tab_width_ff : 5'd1;
      indent_sum = {1'b0, indent_ff} + (LEVEL_BITS + 1)'(add_amount);

      indent_in = indent_ff;
      if (cmd.clr_indent) begin
         indent_in = '0;
      end else if (cmd.add_space || cmd.add_tab) begin
         indent_in = indent_sum[LEVEL_BITS] ? '1 : indent_sum[LEVEL_BITS-1:0];
      end

      comment_in = comment_ff;
      if (cmd.clr_comment) begin
         comment_in = 1'b0;
      end else if (cmd.set_comment) begin
         comment_in = 1'b1;
      end

      newline_in = newline_ff;
      if (cmd.clr_newline) begin
         newline_in = 1'b0;
      end else if (cmd.set_newline) begin
         newline_in = 1'b1;
      end

      count_in = count_ff;
      top_in   = top_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = indent_ff;
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         top_in   = (count_ff == CNT_W'(2)) ? '0 : rd_data_ff;
      end

      target_in  = target_ff;
      emitted_in = emitted_ff;
      if (cmd.load_target) begin
         target_in  = cmd.target_zero ? '0 : indent_ff;
         emitted_in = '0;
      end else if (cmd.pop) begin
         emitted_in = emitted_ff + EMIT_W'(1);
      end

      tab_width_in = (csr_valid && csr_ready) ? csr_write_data : tab_width_ff;

      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CNT_W'(1);
         top_ff       <= '0;
         indent_ff    <= '0;
         comment_ff   <= 1'b0;
         newline_ff   <= 1'b0;
         tab_width_ff <= TAB_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
         emitted_ff   <= '0;
      end else begin
         count_ff     <= count_in;
         top_ff       <= top_in;
         indent_ff    <= indent_in;
         comment_ff   <= comment_in;
         newline_ff   <= newline_in;
         tab_width_ff <= tab_width_in;
         rsp_valid_ff <= rsp_valid_in;
         emitted_ff   <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      if (cmd.emit) begin
         kind_ff <= cmd.emit_kind;
         last_ff <= cmd.emit_last;
         ovf_ff  <= cmd.emit_ovf;
      end
   end

   assign emitted_next = {1'b0, emitted_ff} + (EMIT_W + 1)'(1);

   always_comb begin
      st.byte_class    = classify(req_char_code);
      st.in_comment    = comment_ff;
      st.seen_newline  = newline_ff;
      st.indent_gt_top = indent_ff > top_ff;
      st.indent_lt_top = indent_ff < top_ff;
      st.stack_full    = count_ff == CNT_W'(STACK_DEPTH);
      st.above_base    = count_ff > CNT_W'(1);
      // Another level stays to be closed after the pop now pending.
      st.more          = (count_ff > CNT_W'(2)) &&
                         (emitted_next < (EMIT_W + 1)'(MAX_TOKENS)) &&
                         (rd_data_ff > target_ff);
      st.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_token_kind     = kind_ff;
   assign rsp_last_token     = last_ff;
   assign rsp_stack_overflow = ovf_ff;

endmodule

// ===== rtl/core/its_ctrl.sv =====
// Controller of the indentation token scanner: decides per byte and runs
// the dedent loop. Uses its_pkg; drives its_datapath through its_cmd_type.
module its_ctrl import its_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_valid_indent,
   input  logic           req_valid_dedent,
   input  logic           req_valid_newline,
   input  its_status_type st,
   output its_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_FETCH = 3'b010,
      S_POP   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      accept   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.take_ready = st.out_free;
            accept         = req_valid && st.out_free;
            if (accept) begin
               case (st.byte_class)
                  CLS_EOF: begin
                     cmd.clr_comment = 1'b1;
                     cmd.clr_newline = 1'b1;
                     cmd.clr_indent  = 1'b1;
                     if (req_valid_dedent && st.above_base) begin
                        cmd.load_target = 1'b1;
                        cmd.target_zero = 1'b1;
                        state_in        = S_FETCH;
                     end
                  end
                  CLS_NEWLINE: begin
                     cmd.clr_comment = 1'b1;
                     cmd.set_newline = 1'b1;
                     cmd.clr_indent  = 1'b1;
                  end
                  default: begin
                     if (!st.in_comment) begin
                        case (st.byte_class)
                           CLS_SPACE: cmd.add_space   = 1'b1;
                           CLS_TAB:   cmd.add_tab     = 1'b1;
                           CLS_HASH:  cmd.set_comment = 1'b1;
                           CLS_OTHER: begin
                              cmd.clr_newline = 1'b1;
                              cmd.clr_indent  = 1'b1;
                              if (st.seen_newline) begin
                                 if (st.indent_gt_top && req_valid_indent) begin
                                    cmd.push      = !st.stack_full;
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = TOK_INDENT;
                                    cmd.emit_last = 1'b1;
                                    cmd.emit_ovf  = st.stack_full;
                                 end else if (st.indent_lt_top && req_valid_dedent) begin
                                    cmd.load_target = 1'b1;
                                    state_in        = S_FETCH;
                                 end else if (req_valid_newline) begin
                                    cmd.emit      = 1'b1;
                                    cmd.emit_kind = TOK_NEWLINE;
                                    cmd.emit_last = 1'b1;
                                 end
                              end
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
               endcase
            end
         end
         S_FETCH: begin
            // Read the level below the top so the pop knows whether it is the last.
            cmd.rd_below = 1'b1;
            state_in     = S_POP;
         end
         S_POP: begin
            if (st.out_free) begin
               cmd.pop       = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = TOK_DEDENT;
               cmd.emit_last = !st.more;
               state_in      = st.more ? S_FETCH : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/indentation_token_scanner_unit.sv =====
// Top level of the indentation token scanner.
// Instantiates its_ctrl and its_datapath; uses its_pkg.
//
// Usage:
// The req_ channel carries one source byte per transaction together with the
// parser's flags saying which token kinds it accepts at this point. The rsp_
// channel returns INDENT, DEDENT and NEWLINE tokens; rsp_last_token marks the
// final token caused by one byte. The csr_ channel writes the tab width and
// is always ready; write it only while the scanner is idle.
// A byte that causes no token or a single token is taken while the scanner
// is idle and the result register is free, and its token is in the result
// register on the next cycle. A byte that closes levels (a dedent or end of
// input) runs, per DEDENT, a fetch state that reads the level stack memory
// for the next level down and a pop state; no byte is taken during that burst.
// Reset clears the level stack to its base level, the indent counter and the
// comment and newline marks, and sets the tab width to 4. The stack memory
// needs no clearing, since only entries that were pushed are ever used.
// While rsp_stall holds a token, the result register keeps it, and req_stall
// stays high until the receiver takes it, whatever the next byte would cause.
module indentation_token_scanner_unit import its_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int LEVEL_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_valid_indent,
   input  logic       req_valid_dedent,
   input  logic       req_valid_newline,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_token_kind,
   output logic       rsp_last_token,
   output logic       rsp_stack_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_write_data
);

   its_cmd_type    cmd;
   its_status_type st;

   // The tab width register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // A byte is taken only while the controller is waiting for one and the
   // result register can hold whatever token the byte produces.
   assign req_stall = !cmd.take_ready;

   its_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_valid_indent  (req_valid_indent),
      .req_valid_dedent  (req_valid_dedent),
      .req_valid_newline (req_valid_newline),
      .st                (st),
      .cmd               (cmd)
   );

   its_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .LEVEL_BITS  (LEVEL_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_char_code      (req_char_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .st                 (st),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_last_token     (rsp_last_token),
      .rsp_stack_overflow (rsp_stack_overflow)
   );

   // A pop never removes the base level.
   assert property (@(posedge clock) disable iff (reset) cmd.pop |-> st.above_base)
      else $error("pop issued with only the base level on the stack");

   // A push never goes past the last stack entry.
   assert property (@(posedge clock) disable iff (reset) cmd.push |-> !st.stack_full)
      else $error("push issued into a full stack");

   // A token is never loaded over one that the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |-> st.out_free)
      else $error("token loaded while the result register is held");

   // No new byte is taken during a dedent burst.
   assert property (@(posedge clock) disable iff (reset) cmd.rd_below |-> req_stall)
      else $error("input taken during a dedent burst");

endmodule

// ===== tb/sv/indentation_token_scanner_unit_checker.sv =====
// Checker for the indentation token scanner: follows the byte, token and tab width
// channels, predicts the token stream and compares it with what the scanner returns.
// Depends on its_pkg for byte codes and token kinds.
module indentation_token_scanner_unit_checker import its_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int LEVEL_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_valid_indent,
   input  logic       req_valid_dedent,
   input  logic       req_valid_newline,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_token_kind,
   input  logic       rsp_last_token,
   input  logic       rsp_stack_overflow,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [4:0] csr_write_data,
   output int         failures,
   output int         outstanding
);

   localparam longint unsigned COL_MAX = (64'd1 << LEVEL_BITS) - 1;

   typedef struct packed {
      token_kind_type kind;
      logic           last;
      logic           ovf;
   } scan_token_type;

   // Shadow copy of the scanner state.
   logic [LEVEL_BITS-1:0] open_levels [STACK_DEPTH];
   int                    depth;
   logic [LEVEL_BITS-1:0] col;
   logic                  seen_nl;
   logic                  in_comment;
   logic [4:0]            tab_cols;

   scan_token_type expected_tokens[$];
   int             errs = 0;

   function automatic void widen(input longint unsigned cols);
      if (cols > COL_MAX - col) begin
         col = COL_MAX[LEVEL_BITS-1:0];
      end else begin
         col = col + cols[LEVEL_BITS-1:0];
      end
   endfunction

   // Works out the tokens that one accepted byte causes and queues them.
   task automatic scan_byte(input logic [7:0] c, input logic vi, input logic vd,
                            input logic vn);
      scan_token_type        burst[$];
      logic [LEVEL_BITS-1:0] top;
      top = open_levels[depth-1];
      if (c == CHAR_EOF) begin
         if (vd) begin
            while (depth > 1 && burst.size() < MAX_TOKENS) begin
               depth--;
               burst.push_back('{kind: TOK_DEDENT, last: 1'b0, ovf: 1'b0});
            end
         end
         in_comment = 1'b0;
         seen_nl    = 1'b0;
         col        = '0;
      end else if (c == CHAR_NEWLINE) begin
         in_comment = 1'b0;
         seen_nl    = 1'b1;
         col        = '0;
      end else if (in_comment) begin
         // Comment text is dropped.
      end else if (c == CHAR_SPACE) begin
         widen(1);
      end else if (c == CHAR_TAB) begin
         widen(tab_cols);
      end else if (c == CHAR_CR) begin
         // Carriage returns are dropped.
      end else if (c == CHAR_HASH) begin
         in_comment = 1'b1;
      end else begin
         if (seen_nl) begin
            if (col > top && vi) begin
               if (depth < STACK_DEPTH) begin
                  open_levels[depth] = col;
                  depth++;
                  burst.push_back('{kind: TOK_INDENT, last: 1'b0, ovf: 1'b0});
               end else begin
                  burst.push_back('{kind: TOK_INDENT, last: 1'b0, ovf: 1'b1});
               end
            end else if (col < top && vd) begin
               // Close every level deeper than the new indent, at most one burst.
               while (depth > 1 && burst.size() < MAX_TOKENS &&
                      open_levels[depth-1] > col) begin
                  depth--;
                  burst.push_back('{kind: TOK_DEDENT, last: 1'b0, ovf: 1'b0});
               end
            end else if (vn) begin
               burst.push_back('{kind: TOK_NEWLINE, last: 1'b0, ovf: 1'b0});
            end
         end
         seen_nl = 1'b0;
         col     = '0;
      end
      if (burst.size() > 0) begin
         burst[$].last = 1'b1;
      end
      foreach (burst[i]) begin
         expected_tokens.push_back(burst[i]);
      end
   endtask

   always @(posedge clock) begin : watch
      scan_token_type want;
      if (reset) begin
         foreach (open_levels[i]) begin
            open_levels[i] = '0;
         end
         depth      = 1;
         col        = '0;
         seen_nl    = 1'b0;
         in_comment = 1'b0;
         tab_cols   = TAB_WIDTH_RESET;
         expected_tokens.delete();
      end else begin
         // A token can never come from a byte taken at the same edge, so the
         // comparison goes first.
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: token_kind %0d, last_token %0d, stack_overflow %0d",
                      rsp_token_kind, rsp_last_token, rsp_stack_overflow);
               errs++;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_kind !== want.kind) begin
                  $error("token_kind mismatch: expected %0d, actual %0d",
                         want.kind, rsp_token_kind);
                  errs++;
               end
               if (rsp_last_token !== want.last) begin
                  $error("last_token mismatch: expected %0d, actual %0d",
                         want.last, rsp_last_token);
                  errs++;
               end
               if (rsp_stack_overflow !== want.ovf) begin
                  $error("stack_overflow mismatch: expected %0d, actual %0d",
                         want.ovf, rsp_stack_overflow);
                  errs++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            tab_cols = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            scan_byte(req_char_code, req_valid_indent, req_valid_dedent, req_valid_newline);
         end
      end
      failures    <= errs;
      outstanding <= expected_tokens.size();
   end

endmodule

// ===== tb/sv/indentation_token_scanner_unit_tb.sv =====
// Testbench top for the indentation token scanner: drives source bytes and tab widths
// and gives the verdict. Depends on its_pkg, the scanner RTL and the checker module.
module indentation_token_scanner_unit_tb import its_pkg::*;;

   localparam int STACK_DEPTH = 32;
   localparam int LEVEL_BITS  = 16;
   localparam int DRAIN_LIMIT = 50000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_code;
   logic       req_valid_indent;
   logic       req_valid_dedent;
   logic       req_valid_newline;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_token_kind;
   logic       rsp_last_token;
   logic       rsp_stack_overflow;
   logic       csr_valid;
   logic       csr_ready;
   logic [4:0] csr_write_data;

   int failures;
   int outstanding;

   // Idle rates of the two sides, in percent, and the tab width last written.
   int idle_pct  = 0;
   int stall_pct = 0;
   int tab_cols  = 4;
   int sent      = 0;

   // Indent columns of the levels the stimulus believes are open. It only
   // steers the generator toward sensible programs; checking never uses it.
   int open_cols[$] = '{0};

   always #6 clock = ~clock;

   indentation_token_scanner_unit #(
      .STACK_DEPTH(STACK_DEPTH),
      .LEVEL_BITS (LEVEL_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_valid_indent  (req_valid_indent),
      .req_valid_dedent  (req_valid_dedent),
      .req_valid_newline (req_valid_newline),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_last_token    (rsp_last_token),
      .rsp_stack_overflow(rsp_stack_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_write_data    (csr_write_data)
   );

   indentation_token_scanner_unit_checker #(
      .STACK_DEPTH(STACK_DEPTH),
      .LEVEL_BITS (LEVEL_BITS)
   ) token_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_valid_indent  (req_valid_indent),
      .req_valid_dedent  (req_valid_dedent),
      .req_valid_newline (req_valid_newline),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_last_token    (rsp_last_token),
      .rsp_stack_overflow(rsp_stack_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_write_data    (csr_write_data),
      .failures          (failures),
      .outstanding       (outstanding)
   );

   // The token receiver stalls at random. The rate changes with the phase, so
   // stalls land on single tokens as well as inside long dedent bursts.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Parser flags are mostly set, so that well-formed lines usually produce
   // a token, but each one is also cleared often enough to matter.
   function automatic logic accept_flag();
      return $urandom_range(9) != 0;
   endfunction

   // A byte that is none of the bytes with a meaning of their own.
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_CR ||
                 c == CHAR_SPACE || c == CHAR_HASH);
      return c;
   endfunction

   // Anything that may sit inside a comment without ending it.
   function automatic logic [7:0] comment_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while (c == CHAR_NEWLINE);
      return c;
   endfunction

   // Offers one byte and returns at the rising edge that accepts it. All
   // changes happen at the falling edge. Valid is only lowered when the
   // sender decides to idle, so back-to-back transactions keep it high.
   task automatic send_byte(input logic [7:0] code, input logic vi, input logic vd,
                            input logic vn);
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) begin
            @(negedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_char_code     <= code;
      req_valid_indent  <= vi;
      req_valid_dedent  <= vd;
      req_valid_newline <= vn;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent++;
   endtask

   task automatic send_any(input logic [7:0] code);
      send_byte(code, accept_flag(), accept_flag(), accept_flag());
   endtask

   task automatic send_text(input string s, input logic vi, input logic vd, input logic vn);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], vi, vd, vn);
      end
   endtask

   // Leading whitespace worth the given number of columns, built from tabs
   // and spaces in random order with the odd carriage return mixed in. With
   // a tab width of zero, tabs are thrown in anyway since they add nothing.
   task automatic send_indent(input int cols);
      int tabs;
      int spaces;
      tabs   = 0;
      spaces = cols;
      if (tab_cols > 0 && $urandom_range(1) == 1) begin
         tabs   = cols / tab_cols;
         spaces = cols % tab_cols;
      end
      if (tab_cols == 0) begin
         tabs = $urandom_range(0, 2);
      end
      while (tabs + spaces > 0) begin
         if ($urandom_range(9) == 0) begin
            send_any(CHAR_CR);
         end
         if (tabs > 0 && (spaces == 0 || $urandom_range(1) == 1)) begin
            send_any(CHAR_TAB);
            tabs--;
         end else begin
            send_any(CHAR_SPACE);
            spaces--;
         end
      end
   endtask

   // Drops valid, lets every predicted token come back and then lets the clock
   // run on, so that no byte is still in flight inside the scanner.
   task automatic drain();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tab_width(input logic [4:0] cols);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_write_data <= cols;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      tab_cols = cols;
   endtask

   // One line of the nesting ladder: the column count grows strictly with
   // the level as long as the tab width is at least 4.
   task automatic send_ladder_line(input int lvl);
      send_any(CHAR_NEWLINE);
      repeat (lvl / 4) send_any(CHAR_TAB);
      repeat (lvl % 4) send_any(CHAR_SPACE);
      send_byte(plain_byte(), 1'b1, 1'b1, 1'b1);
   endtask

   // Fills the level stack, runs two indents into the full stack, drops back
   // to level 10 in one long dedent burst and closes the rest at end of input.
   task automatic deep_nesting();
      send_byte(CHAR_EOF, accept_flag(), 1'b1, accept_flag());
      for (int lvl = 1; lvl <= STACK_DEPTH + 1; lvl++) begin
         send_ladder_line(lvl);
      end
      send_ladder_line(10);
      send_byte(CHAR_EOF, accept_flag(), 1'b1, accept_flag());
      open_cols = '{0};
   endtask

   // One random chunk of source. Most chunks are well-formed lines that go
   // deeper, stay, return to an open level or land between two levels; the
   // rest are bursts of raw bytes and end-of-input markers.
   task automatic random_line();
      int   pick;
      int   top;
      int   cols;
      logic vi;
      logic vd;
      logic vn;
      pick = $urandom_range(99);
      top  = open_cols[$];
      if (pick < 8) begin
         repeat ($urandom_range(1, 6)) send_any(8'($urandom_range(1, 255)));
      end else if (pick < 12) begin
         vd = accept_flag();
         send_byte(CHAR_EOF, accept_flag(), vd, accept_flag());
         if (vd) begin
            open_cols = '{0};
         end
      end else begin
         if ($urandom_range(4) == 0) begin
            send_any(CHAR_CR);
         end
         send_any(CHAR_NEWLINE);
         // Now and then a blank or comment-only line, which yields nothing.
         if ($urandom_range(6) == 0) begin
            send_indent($urandom_range(0, 8));
            if ($urandom_range(1) == 1) begin
               send_any(CHAR_HASH);
               repeat ($urandom_range(0, 4)) send_any(comment_byte());
            end
            send_any(CHAR_NEWLINE);
         end
         pick = $urandom_range(9);
         if (open_cols.size() > 12 && pick < 4) begin
            pick = 6;
         end
         if (pick < 4) begin
            cols = top + $urandom_range(1, 10);
         end else if (pick < 6) begin
            cols = top;
         end else if (pick < 9) begin
            cols = open_cols[$urandom_range(0, open_cols.size() - 1)];
         end else begin
            cols = $urandom_range(0, top);
         end
         send_indent(cols);
         vi = accept_flag();
         vd = accept_flag();
         vn = accept_flag();
         send_byte(plain_byte(), vi, vd, vn);
         if (cols > top && vi) begin
            if (open_cols.size() < STACK_DEPTH) begin
               open_cols.push_back(cols);
            end
         end else if (cols < top && vd) begin
            while (open_cols.size() > 1 && open_cols[$] > cols) begin
               void'(open_cols.pop_back());
            end
         end
         // The rest of the line: whitespace here only adds to the indent and yields no token.
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(3))
               0: begin
                  send_any(CHAR_SPACE);
               end
               1: begin
                  send_any(CHAR_TAB);
               end
               2: begin
                  send_any(CHAR_CR);
               end
               default: begin
                  send_any(plain_byte());
               end
            endcase
         end
         if ($urandom_range(6) == 0) begin
            send_any(CHAR_HASH);
            repeat ($urandom_range(0, 5)) send_any(comment_byte());
         end
      end
   endtask

   // One phase: settle the scanner, set the tab width and the idle rates,
   // run the optional nesting ladder and then random chunks up to the quota.
   task automatic run_phase(input int idle, input int stall, input int cols, input int quota,
                            input bit nest);
      int start;
      drain();
      write_tab_width(cols[4:0]);
      idle_pct  = idle;
      stall_pct = stall;
      if (nest) begin
         deep_nesting();
      end
      start = sent;
      while (sent - start < quota) begin
         random_line();
      end
   endtask

   // Hard stop in case the scanner hangs a handshake.
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      req_valid         = 1'b0;
      req_char_code     = '0;
      req_valid_indent  = 1'b0;
      req_valid_dedent  = 1'b0;
      req_valid_newline = 1'b0;
      csr_valid         = 1'b0;
      csr_write_data    = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset tab width of 4, with no idling.
      // A plain byte with no newline before it yields nothing.
      send_text("a", 1'b1, 1'b1, 1'b1);
      // Same indent as the base level: NEWLINE.
      send_text("\nb", 1'b1, 1'b1, 1'b1);
      // Space, tab and a skipped carriage return make 5 columns; the top
      // code 0xFF opens the first level.
      send_text("\n \t\r", 1'b1, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
      // A comment-only line, then two tabs open a second level at 8.
      send_text("\n#", 1'b1, 1'b1, 1'b1);
      send_byte(8'h7F, 1'b1, 1'b1, 1'b1);
      send_text("\n\t\tc", 1'b1, 1'b1, 1'b1);
      // Three columns match no open level: both levels close, and popping
      // stops at the base even though it is shallower than the line.
      send_text("\n   d", 1'b1, 1'b1, 1'b1);
      // Deeper, but the parser takes no INDENT here, so NEWLINE instead.
      send_text("\n\te", 1'b0, 1'b1, 1'b1);
      // Deeper with every flag clear: nothing at all.
      send_text("\n f", 1'b0, 1'b0, 1'b0);
      send_text("\n  g", 1'b1, 1'b1, 1'b1);
      // End of input without DEDENT leaves the level open; with it, closes it.
      send_byte(CHAR_EOF, 1'b1, 1'b0, 1'b1);
      send_byte(CHAR_EOF, 1'b0, 1'b1, 1'b0);

      // Random part. The phases cover every idling mix and the tab width
      // extremes, including widths outside the usual range and zero.
      run_phase(0, 0, 31, 35, 1'b0);
      run_phase(74, 0, 1, 35, 1'b0);
      run_phase(0, 74, 16, 35, 1'b1);
      run_phase(30, 30, 0, 35, 1'b0);
      run_phase(0, 0, $urandom_range(2, 15), 35, 1'b0);
      run_phase(30, 30, $urandom_range(0, 31), 35, 1'b0);

      drain();
      if (outstanding != 0) begin
         $error("%0d expected tokens never arrived", outstanding);
      end
      if (failures == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
